// File: src/cubic_spline_point_tangent_arclength_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic spline core
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SPLINE_POINT_TANGENT_ARCLENGTH_CORE_ASSERT_SVH
`define CUBIC_SPLINE_POINT_TANGENT_ARCLENGTH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CSPTAC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSPTAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked around reset.
`define CSPTAC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/csptac_pkg.sv
// ----------------------------------------------------------------------------
// Cubic spline core package
// Widths, quadrature tables, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package csptac_pkg;

   localparam int QUAD_POINTS_DEF = 5;

   localparam int T_W     = 17;
   localparam int COEF_W  = 16;
   localparam int PW_W    = 35;
   localparam int PROD_W  = COEF_W + PW_W + 1;
   localparam int WSUM_W  = PROD_W + 2;
   localparam int W16_W   = 26;
   localparam int PPROD_W = W16_W + COEF_W;
   localparam int ACC_W   = PPROD_W + 2;
   localparam int OUT_W   = 32;

   localparam int FRONT_STAGES = 2;
   localparam int EVAL_STAGES  = 4;
   localparam int SQRT_STAGES  = 32;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_BASIS_COL0 = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BASIS_COL3 = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CTRL_POINT0 = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CTRL_POINT3 = 4'd7;

   localparam logic [T_W-1:0]  T_ONE  = 17'h10000;
   localparam logic [PW_W-1:0] PW_ONE = 35'h1_0000_0000;

   localparam logic [63:0] ONE30  = 64'd1073741824;
   localparam logic [63:0] NODE_B = (64'd5384693 * ONE30 + 64'd5000000) / 64'd10000000;
   localparam logic [63:0] NODE_C = (64'd90617985 * ONE30 + 64'd50000000) / 64'd100000000;
   localparam logic [63:0] WGT_A  = (64'd568889 * 64'd65536 + 64'd500000) / 64'd1000000;
   localparam logic [63:0] WGT_B  = (64'd47862867 * 64'd65536 + 64'd50000000) / 64'd100000000;
   localparam logic [63:0] WGT_C  = (64'd23692688 * 64'd65536 + 64'd50000000) / 64'd100000000;

   // Sample offsets (node + 1) in Q1.30 and quadrature weights in Q0.16.
   localparam logic [30:0] QUAD_U [QUAD_POINTS_DEF] = '{
      ONE30[30:0],
      31'(ONE30 + NODE_B),
      31'(ONE30 - NODE_B),
      31'(ONE30 + NODE_C),
      31'(ONE30 - NODE_C)
   };

   localparam logic [15:0] QUAD_WGT [QUAD_POINTS_DEF] = '{
      WGT_A[15:0], WGT_B[15:0], WGT_B[15:0], WGT_C[15:0], WGT_C[15:0]
   };

   typedef logic [3:0][PW_W-1:0]  pw_vec_type;
   typedef logic [3:0][63:0]      basis_type;
   typedef logic [3:0][47:0]      points_type;
   typedef logic [2:0][OUT_W-1:0] comp3_type;

   typedef struct packed {
      basis_type  basis;
      points_type points;
   } cfg_type;

endpackage

`default_nettype wire

// File: src/csptac_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one curve parameter word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csptac_req_if;
   logic        valid;
   logic        ready;
   logic [16:0] curve_param;

   modport source (output valid, output curve_param, input ready);
   modport sink (input valid, input curve_param, output ready);
endinterface

`default_nettype wire

// File: src/csptac_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Carries point, tangent and arc length words with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csptac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] tangent_x;
   logic signed [31:0] tangent_y;
   logic signed [31:0] tangent_z;
   logic [31:0]        arc_length;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output tangent_x, output tangent_y, output tangent_z,
                   output arc_length, input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 input tangent_x, input tangent_y, input tangent_z,
                 input arc_length, output ready);
endinterface

`default_nettype wire

// File: src/csptac_front.sv
// ----------------------------------------------------------------------------
// Parameter front end
// Clamps t, forms its powers and the quadrature sample parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module csptac_front #(
   parameter int QUAD_POINTS = csptac_pkg::QUAD_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [16:0]            t_in,
   output csptac_pkg::pw_vec_type pw_point,
   output csptac_pkg::pw_vec_type pw_tangent,
   output csptac_pkg::pw_vec_type pw_sample [QUAD_POINTS],
   output logic [16:0]            t_out
);

   function automatic csptac_pkg::pw_vec_type deriv_weights(input logic [16:0] tv,
                                                           input logic [32:0] tsq);
      csptac_pkg::pw_vec_type w;
      w[0] = {1'b0, tsq, 1'b0} + {2'b00, tsq};
      w[1] = {1'b0, tv, 17'b0};
      w[2] = csptac_pkg::PW_ONE;
      w[3] = '0;
      return w;
   endfunction

   logic [16:0] t_clamp;
   logic [33:0] t2_full;
   logic [47:0] s_full [QUAD_POINTS];
   logic [16:0] s_f1_in [QUAD_POINTS];

   logic [16:0] t_f1_ff;
   logic [32:0] t2_f1_ff;
   logic [16:0] s_f1_ff [QUAD_POINTS];

   logic [49:0] t3_full;
   logic [33:0] s2_full [QUAD_POINTS];

   logic [16:0] t_f2_ff;
   logic [32:0] t2_f2_ff;
   logic [32:0] t3_f2_ff;
   logic [16:0] s_f2_ff [QUAD_POINTS];
   logic [32:0] s2_f2_ff [QUAD_POINTS];

   always_comb begin
      t_clamp = (t_in > csptac_pkg::T_ONE) ? csptac_pkg::T_ONE : t_in;
      t2_full = t_clamp * t_clamp;
      for (int k = 0; k < QUAD_POINTS; k++) begin
         s_full[k]  = t_clamp * csptac_pkg::QUAD_U[k] + 48'h4000_0000;
         s_f1_in[k] = s_full[k][47:31];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_f1_ff  <= t_clamp;
         t2_f1_ff <= t2_full[32:0];
         for (int k = 0; k < QUAD_POINTS; k++) begin
            s_f1_ff[k] <= s_f1_in[k];
         end
      end
   end

   always_comb begin
      t3_full = t2_f1_ff * t_f1_ff + 50'd32768;
      for (int k = 0; k < QUAD_POINTS; k++) begin
         s2_full[k] = s_f1_ff[k] * s_f1_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_f2_ff  <= t_f1_ff;
         t2_f2_ff <= t2_f1_ff;
         t3_f2_ff <= t3_full[48:16];
         for (int k = 0; k < QUAD_POINTS; k++) begin
            s_f2_ff[k]  <= s_f1_ff[k];
            s2_f2_ff[k] <= s2_full[k][32:0];
         end
      end
   end

   always_comb begin
      pw_point[0] = {2'b00, t3_f2_ff};
      pw_point[1] = {2'b00, t2_f2_ff};
      pw_point[2] = {2'b00, t_f2_ff, 16'b0};
      pw_point[3] = csptac_pkg::PW_ONE;
      pw_tangent  = deriv_weights(t_f2_ff, t2_f2_ff);
      for (int k = 0; k < QUAD_POINTS; k++) begin
         pw_sample[k] = deriv_weights(s_f2_ff[k], s2_f2_ff[k]);
      end
   end

   assign t_out = t_f2_ff;

endmodule

`default_nettype wire

// File: src/csptac_eval.sv
// ----------------------------------------------------------------------------
// Curve evaluator
// Four-stage basis weighting of the control points for one weight vector.
// ----------------------------------------------------------------------------
`default_nettype none

module csptac_eval (
   input  logic                   clock,
   input  logic                   adv,
   input  csptac_pkg::pw_vec_type pw,
   input  csptac_pkg::cfg_type    cfg,
   output csptac_pkg::comp3_type  res
);

   localparam int PROD_W  = csptac_pkg::PROD_W;
   localparam int WSUM_W  = csptac_pkg::WSUM_W;
   localparam int W16_W   = csptac_pkg::W16_W;
   localparam int PPROD_W = csptac_pkg::PPROD_W;
   localparam int ACC_W   = csptac_pkg::ACC_W;

   localparam logic signed [WSUM_W-1:0] HALF_W = WSUM_W'(64'd134217728);
   localparam logic signed [ACC_W-1:0]  HALF_A = ACC_W'(64'd128);
   localparam logic signed [ACC_W-9:0]  SAT_HI = (ACC_W-8)'(64'sd2147483647);
   localparam logic signed [ACC_W-9:0]  SAT_LO = (ACC_W-8)'(-64'sd2147483648);

   logic signed [PROD_W-1:0]  prod_in [4][4];
   logic signed [PROD_W-1:0]  prod_ff [4][4];
   logic signed [WSUM_W-1:0]  wsum [4];
   logic signed [WSUM_W-1:0]  wrnd [4];
   logic signed [W16_W-1:0]   w16_ff [4];
   logic signed [PPROD_W-1:0] pp_in [4][3];
   logic signed [PPROD_W-1:0] pp_ff [4][3];
   logic signed [ACC_W-1:0]   acc [3];
   logic signed [ACC_W-1:0]   arnd [3];
   logic signed [ACC_W-9:0]   q [3];
   csptac_pkg::comp3_type     res_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = $signed(cfg.basis[i][16*j +: 16]) * $signed({1'b0, pw[j]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         wsum[i] = prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2] + prod_ff[i][3];
         wrnd[i] = wsum[i] + HALF_W;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            w16_ff[i] <= wrnd[i][WSUM_W-1:28];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int c = 0; c < 3; c++) begin
            pp_in[i][c] = w16_ff[i] * $signed(cfg.points[i][16*c +: 16]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff <= pp_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c]  = pp_ff[0][c] + pp_ff[1][c] + pp_ff[2][c] + pp_ff[3][c];
         arnd[c] = acc[c] + HALF_A;
         q[c]    = arnd[c][ACC_W-1:8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            if (q[c] > SAT_HI) begin
               res_ff[c] <= SAT_HI[31:0];
            end else if (q[c] < SAT_LO) begin
               res_ff[c] <= SAT_LO[31:0];
            end else begin
               res_ff[c] <= q[c][31:0];
            end
         end
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// File: src/csptac_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor square root of a 64-bit radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module csptac_sqrt (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [2*csptac_pkg::SQRT_STAGES-1:0] radicand,
   output logic [csptac_pkg::SQRT_STAGES-1:0]   root
);

   localparam int STAGES = csptac_pkg::SQRT_STAGES;
   localparam int VAL_W  = 2 * STAGES;
   localparam int REM_W  = STAGES + 3;

   logic [VAL_W-1:0]  val_w  [STAGES+1];
   logic [REM_W-1:0]  rem_w  [STAGES+1];
   logic [STAGES-1:0] root_w [STAGES+1];

   assign val_w[0]  = radicand;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [STAGES-1:0] root_in;
      logic [REM_W-1:0]  rem_ff;
      logic [STAGES-1:0] root_ff;
      logic [VAL_W-1:0]  val_ff;

      always_comb begin
         rem_cat = {rem_w[k][REM_W-3:0], val_w[k][VAL_W-1:VAL_W-2]};
         trial   = {1'b0, root_w[k], 2'b01};
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_w[k][STAGES-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_w[k][STAGES-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            val_ff  <= {val_w[k][VAL_W-3:0], 2'b00};
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign root_w[k+1] = root_ff;
      assign val_w[k+1]  = val_ff;
   end

   assign root = root_w[STAGES];

endmodule

`default_nettype wire

// File: src/cubic_spline_point_tangent_arclength_core.sv
// ----------------------------------------------------------------------------
// Cubic spline point, tangent and arc length core
// Evaluates a configured cubic spline at a parameter t in Q1.16.
// ----------------------------------------------------------------------------
// The req channel takes one curve parameter word per cycle; values above 1.0
// are clamped. The rsp channel returns one word per request, in order, with
// the point, the tangent and the arc length from 0 to t, all in Q16.16.
// The csr port writes the four basis columns and the four control points;
// write them only while no request is in flight.
// A response word is formed through the two front stages, the four evaluator
// stages, two squaring stages, the 32-stage square root and four weighting
// and output stages. Throughput is one word per cycle while the output is
// not stalled. The whole pipeline advances together:
// while a response word waits on a low rsp ready, every stage holds and req
// ready is low; nothing is lost or repeated.
// Reset clears the valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_spline_point_tangent_arclength_core #(
   parameter int QUAD_POINTS = csptac_pkg::QUAD_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   csptac_req_if.sink                         req,
   csptac_rsp_if.source                       rsp,
   input  logic                               csr_wen,
   input  logic [csptac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csptac_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SQRT_STAGES = csptac_pkg::SQRT_STAGES;
   localparam int T_DELAY     = csptac_pkg::EVAL_STAGES + 2 + SQRT_STAGES + 2;
   localparam int RES_DELAY   = 2 + SQRT_STAGES + 3;
   localparam int PIPE_STAGES = csptac_pkg::FRONT_STAGES + csptac_pkg::EVAL_STAGES + 2
                                + SQRT_STAGES + 4;

   csptac_pkg::cfg_type cfg_ff;
   logic [PIPE_STAGES-1:0] valid_ff;
   logic adv;

   csptac_pkg::pw_vec_type pw_point;
   csptac_pkg::pw_vec_type pw_tangent;
   csptac_pkg::pw_vec_type pw_sample [QUAD_POINTS];
   logic [16:0]            t_f2;

   csptac_pkg::comp3_type pt_res;
   csptac_pkg::comp3_type tg_res;
   csptac_pkg::comp3_type ts_res [QUAD_POINTS];

   logic signed [63:0] sq_full [QUAD_POINTS][3];
   logic [62:0]        sq_ff   [QUAD_POINTS][3];
   logic [63:0]        sum_ff  [QUAD_POINTS];
   logic [31:0]        root_w  [QUAD_POINTS];
   logic [47:0]        wp_ff   [QUAD_POINTS];
   logic [50:0]        wtot;
   logic [34:0]        s16_ff;
   logic [51:0]        lp_ff;
   logic [52:0]        lrnd;

   logic [16:0]           t_dly_ff  [T_DELAY];
   csptac_pkg::comp3_type pt_dly_ff [RES_DELAY];
   csptac_pkg::comp3_type tg_dly_ff [RES_DELAY];

   csptac_pkg::comp3_type out_pt_ff;
   csptac_pkg::comp3_type out_tg_ff;
   logic [31:0]           out_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index) inside
            [csptac_pkg::REG_BASIS_COL0:csptac_pkg::REG_BASIS_COL3]: begin
               cfg_ff.basis[csr_index[1:0]] <= csr_wdata;
            end
            [csptac_pkg::REG_CTRL_POINT0:csptac_pkg::REG_CTRL_POINT3]: begin
               cfg_ff.points[csr_index[1:0]] <= csr_wdata[47:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign adv       = !valid_ff[PIPE_STAGES-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_STAGES-2:0], req.valid};
      end
   end

   csptac_front #(
      .QUAD_POINTS (QUAD_POINTS)
   ) u_front (
      .clock      (clock),
      .adv        (adv),
      .t_in       (req.curve_param),
      .pw_point   (pw_point),
      .pw_tangent (pw_tangent),
      .pw_sample  (pw_sample),
      .t_out      (t_f2)
   );

   csptac_eval u_eval_point (
      .clock (clock),
      .adv   (adv),
      .pw    (pw_point),
      .cfg   (cfg_ff),
      .res   (pt_res)
   );

   csptac_eval u_eval_tangent (
      .clock (clock),
      .adv   (adv),
      .pw    (pw_tangent),
      .cfg   (cfg_ff),
      .res   (tg_res)
   );

   for (genvar k = 0; k < QUAD_POINTS; k++) begin : g_sample
      csptac_eval u_eval_sample (
         .clock (clock),
         .adv   (adv),
         .pw    (pw_sample[k]),
         .cfg   (cfg_ff),
         .res   (ts_res[k])
      );

      csptac_sqrt u_sqrt (
         .clock    (clock),
         .adv      (adv),
         .radicand (sum_ff[k]),
         .root     (root_w[k])
      );
   end

   always_comb begin
      for (int k = 0; k < QUAD_POINTS; k++) begin
         for (int c = 0; c < 3; c++) begin
            sq_full[k][c] = $signed(ts_res[k][c]) * $signed(ts_res[k][c]);
         end
      end
      wtot = '0;
      for (int k = 0; k < QUAD_POINTS; k++) begin
         wtot = wtot + 51'(wp_ff[k]);
      end
      wtot = wtot + 51'd32768;
      lrnd = {1'b0, lp_ff} + 53'd65536;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QUAD_POINTS; k++) begin
            for (int c = 0; c < 3; c++) begin
               sq_ff[k][c] <= sq_full[k][c][62:0];
            end
            sum_ff[k] <= {1'b0, sq_ff[k][0]} + {1'b0, sq_ff[k][1]} + {1'b0, sq_ff[k][2]};
            wp_ff[k]  <= root_w[k] * csptac_pkg::QUAD_WGT[k];
         end
         s16_ff <= wtot[50:16];
         lp_ff  <= s16_ff * t_dly_ff[T_DELAY-1];

         t_dly_ff[0]  <= t_f2;
         for (int i = 1; i < T_DELAY; i++) begin
            t_dly_ff[i] <= t_dly_ff[i-1];
         end
         pt_dly_ff[0] <= pt_res;
         tg_dly_ff[0] <= tg_res;
         for (int i = 1; i < RES_DELAY; i++) begin
            pt_dly_ff[i] <= pt_dly_ff[i-1];
            tg_dly_ff[i] <= tg_dly_ff[i-1];
         end

         out_pt_ff <= pt_dly_ff[RES_DELAY-1];
         out_tg_ff <= tg_dly_ff[RES_DELAY-1];
         if (|lrnd[52:49]) begin
            out_len_ff <= '1;
         end else begin
            out_len_ff <= lrnd[48:17];
         end
      end
   end

   assign rsp.valid      = valid_ff[PIPE_STAGES-1];
   assign rsp.point_x    = out_pt_ff[0];
   assign rsp.point_y    = out_pt_ff[1];
   assign rsp.point_z    = out_pt_ff[2];
   assign rsp.tangent_x  = out_tg_ff[0];
   assign rsp.tangent_y  = out_tg_ff[1];
   assign rsp.tangent_z  = out_tg_ff[2];
   assign rsp.arc_length = out_len_ff;

endmodule

`default_nettype wire

// File: src/csptac_checker.sv
// ----------------------------------------------------------------------------
// Port-level checker for the cubic spline core
// Watches the channel handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_spline_point_tangent_arclength_core_assert.svh"

module csptac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_point_x,
   input logic [31:0] rsp_point_y,
   input logic [31:0] rsp_point_z,
   input logic [31:0] rsp_tangent_x,
   input logic [31:0] rsp_tangent_y,
   input logic [31:0] rsp_tangent_z,
   input logic [31:0] rsp_arc_length
);

   `CSPTAC_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, !rsp_valid, "response valid after reset")

   `CSPTAC_ASSERT_SAME(a_ready_only_on_stall, !req_ready, rsp_valid && !rsp_ready,
      "request ready low without a stalled response")

   `CSPTAC_ASSERT_SAME(a_ready_when_free, !rsp_valid || rsp_ready, req_ready,
      "request ready low while the output can move")

   `CSPTAC_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_z)
      && $stable(rsp_tangent_x) && $stable(rsp_tangent_y) && $stable(rsp_tangent_z)
      && $stable(rsp_arc_length),
      "stalled response word changed")

endmodule

bind cubic_spline_point_tangent_arclength_core csptac_checker u_csptac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_point_x    (rsp.point_x),
   .rsp_point_y    (rsp.point_y),
   .rsp_point_z    (rsp.point_z),
   .rsp_tangent_x  (rsp.tangent_x),
   .rsp_tangent_y  (rsp.tangent_y),
   .rsp_tangent_z  (rsp.tangent_z),
   .rsp_arc_length (rsp.arc_length)
);

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Cubic spline core regression bench
// Writes basis and control point registers, streams curve parameter words
// through the core under several handshake idling profiles, and checks each
// response word (point, tangent, arc length) against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RAND_PER_PHASE = 250;
   localparam int  NUM_PHASES     = 7;
   localparam int  SETTLE_CYCLES  = 60;
   localparam int  HOLD_CYCLES    = 300;
   localparam int  CYCLE_LIMIT    = 600000;
   localparam int  NUM_REGS       = 8;
   localparam int  BEZIER_ROW     = 3;

   localparam longint ND_B = (64'd5384693 * 64'd1073741824 + 64'd5000000) / 64'd10000000;
   localparam longint ND_C = (64'd90617985 * 64'd1073741824 + 64'd50000000) / 64'd100000000;
   localparam longint WT_A = (64'd568889 * 64'd65536 + 64'd500000) / 64'd1000000;
   localparam longint WT_B = (64'd47862867 * 64'd65536 + 64'd50000000) / 64'd100000000;
   localparam longint WT_C = (64'd23692688 * 64'd65536 + 64'd50000000) / 64'd100000000;
   localparam longint GL_NODE [5] = '{0, ND_B, -ND_B, ND_C, -ND_C};
   localparam longint GL_WGT  [5] = '{WT_A, WT_B, WT_B, WT_C, WT_C};

   typedef struct packed {
      logic signed [31:0] px, py, pz, tx, ty, tz;
      logic [31:0]        arc;
   } spline_word_type;

   typedef struct {
      logic [16:0]     param;
      bit              known;
      spline_word_type word;
   } stim_row_type;

   typedef struct {
      bit              known;
      spline_word_type word;
   } send_tag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                               csr_wen   = 1'b0;
   logic [csptac_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [csptac_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   csptac_req_if req_ch ();
   csptac_rsp_if rsp_ch ();

   cubic_spline_point_tangent_arclength_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   longint unsigned basis_reg [4];
   longint unsigned point_reg [4];
   spline_word_type spline_q [$];
   send_tag_type    tag_q [$];
   int              send_idle_pct  = 0;
   int              rsp_stall_pct  = 0;
   bit              hold_request   = 1'b0;
   int              mismatches     = 0;
   int              cycles         = 0;
   bit              failed         = 1'b0;

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.curve_param = '0;
      rsp_ch.ready       = 1'b0;
   end

   function automatic longint sext16(longint unsigned v);
      return longint'(shortint'(v[15:0]));
   endfunction

   function automatic longint round_half_up(longint x, int k);
      return (x + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void curve_at(longint unsigned t, bit deriv,
                                    output logic signed [31:0] res [3]);
      longint unsigned t2 = t * t;
      longint pw [4];
      longint acc [3] = '{0, 0, 0};
      longint w, w16;
      if (!deriv) begin
         pw[0] = longint'((t2 * t + 64'd32768) >> 16);
         pw[1] = longint'(t2);
         pw[2] = longint'(t << 16);
         pw[3] = longint'(1) <<< 32;
      end else begin
         pw[0] = longint'(3 * t2);
         pw[1] = longint'(t << 17);
         pw[2] = longint'(1) <<< 32;
         pw[3] = 0;
      end
      for (int i = 0; i < 4; i++) begin
         w = 0;
         for (int j = 0; j < 4; j++) w += sext16(basis_reg[i] >> (16 * j)) * pw[j];
         w16 = round_half_up(w, 28);
         for (int j = 0; j < 3; j++) acc[j] += w16 * sext16(point_reg[i] >> (16 * j));
      end
      for (int j = 0; j < 3; j++) res[j] = clamp32(round_half_up(acc[j], 8));
   endfunction

   function automatic spline_word_type predict_spline(logic [16:0] param);
      longint unsigned t = param;
      logic signed [31:0] p [3], g [3], s [3];
      longint unsigned total = 0, sq, u, smp, s16, len;
      spline_word_type r;
      if (t > 65536) t = 65536;
      curve_at(t, 1'b0, p);
      curve_at(t, 1'b1, g);
      for (int k = 0; k < 5; k++) begin
         u   = longint'(GL_NODE[k] + (longint'(1) <<< 30));
         smp = (t * u + (64'd1 << 30)) >> 31;
         curve_at(smp, 1'b1, s);
         sq = 0;
         for (int j = 0; j < 3; j++) sq += longint'(s[j]) * longint'(s[j]);
         total += floor_sqrt(sq) * GL_WGT[k];
      end
      s16 = (total + 64'd32768) >> 16;
      len = (s16 * t + 64'd65536) >> 17;
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
      r.px = p[0]; r.py = p[1]; r.pz = p[2];
      r.tx = g[0]; r.ty = g[1]; r.tz = g[2];
      r.arc = len[31:0];
      return r;
   endfunction

   task automatic note_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         failed = 1'b1;
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
      end
   endtask

   // Acceptance on either channel is judged from values that were stable
   // since the preceding falling edge.
   always @(posedge clock) begin
      spline_word_type exp_w;
      send_tag_type    tag;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            tag = tag_q.pop_front();
            spline_q.push_back(tag.known ? tag.word : predict_spline(req_ch.curve_param));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (spline_q.size() == 0) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10) $display("unexpected response word");
            end else begin
               exp_w = spline_q.pop_front();
               note_field("point_x",    exp_w.px,  rsp_ch.point_x);
               note_field("point_y",    exp_w.py,  rsp_ch.point_y);
               note_field("point_z",    exp_w.pz,  rsp_ch.point_z);
               note_field("tangent_x",  exp_w.tx,  rsp_ch.tangent_x);
               note_field("tangent_y",  exp_w.ty,  rsp_ch.tangent_y);
               note_field("tangent_z",  exp_w.tz,  rsp_ch.tangent_z);
               note_field("arc_length", exp_w.arc, rsp_ch.arc_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off when requested.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_param(logic [16:0] param, bit known, spline_word_type word);
      send_tag_type tag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      tag.known = known;
      tag.word  = word;
      tag_q.push_back(tag);
      req_ch.valid       <= 1'b1;
      req_ch.curve_param <= param;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (spline_q.size() != 0 || tag_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(int idx, logic [63:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx[csptac_pkg::CSR_INDEX_W-1:0];
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx <= int'(csptac_pkg::REG_BASIS_COL3)) basis_reg[idx] = value;
      else if (idx <= int'(csptac_pkg::REG_CTRL_POINT3))
         point_reg[idx - int'(csptac_pkg::REG_CTRL_POINT0)] = value & 64'hFFFF_FFFF_FFFF;
      @(negedge clock);
   endtask

   function automatic logic [63:0] pack_col(logic [15:0] c3, logic [15:0] c2,
                                            logic [15:0] c1, logic [15:0] c0);
      return {c0, c1, c2, c3};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] small_point();
      logic [63:0] v;
      for (int j = 0; j < 3; j++) v[16*j +: 16] = 16'($signed($urandom_range(8192)) - 4096);
      v[63:48] = 16'($urandom());
      return v;
   endfunction

   task automatic load_bezier();
      int col0;
      col0 = int'(csptac_pkg::REG_BASIS_COL0);
      write_reg(col0 + 0, pack_col(16'hF000, 16'h3000, 16'hD000, 16'h1000));
      write_reg(col0 + 1, pack_col(16'h3000, 16'hA000, 16'h3000, 16'h0000));
      write_reg(col0 + 2, pack_col(16'hD000, 16'h3000, 16'h0000, 16'h0000));
      write_reg(col0 + 3, pack_col(16'h1000, 16'h0000, 16'h0000, 16'h0000));
      for (int i = 0; i < 4; i++) write_reg(int'(csptac_pkg::REG_CTRL_POINT0) + i, small_point());
   endtask

   task automatic load_setting(int sel);
      case (sel % 5)
         0: load_bezier();
         1: begin
            for (int i = 0; i < NUM_REGS; i++) write_reg(i, rand64());
         end
         2: begin
            for (int i = 0; i < NUM_REGS; i++) write_reg(i, {4{16'h7FFF}});
         end
         3: begin
            for (int i = 0; i < NUM_REGS; i++) write_reg(i, {4{16'h8000}});
         end
         default: begin
            for (int i = 0; i < NUM_REGS; i++) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
         end
      endcase
      write_reg($urandom_range(15, NUM_REGS), rand64());
   endtask

   function automatic logic [16:0] rand_param();
      case ($urandom_range(9))
         0:       return 17'($urandom_range(17'h1FFFF, 17'h10001));
         1:       return $urandom_range(1) ? 17'd0 : csptac_pkg::T_ONE;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   stim_row_type directed [] = '{
      '{17'h00000, 1'b1, '0},
      '{17'h10000, 1'b1, '0},
      '{17'h1FFFF, 1'b1, '0},
      '{17'h00000, 1'b0, '0},
      '{17'h00001, 1'b0, '0},
      '{17'h08000, 1'b0, '0},
      '{17'h0AAAA, 1'b0, '0},
      '{17'h15555, 1'b0, '0},
      '{17'h0FFFF, 1'b0, '0},
      '{17'h10000, 1'b0, '0},
      '{17'h10001, 1'b0, '0},
      '{17'h1FFFF, 1'b0, '0}
   };

   initial begin
      spline_word_type none_w;
      none_w = '0;
      for (int i = 0; i < 4; i++) begin
         basis_reg[i] = 0;
         point_reg[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[r]) begin
         if (r == BEZIER_ROW) begin
            drain_results();
            load_bezier();
         end
         send_param(directed[r].param, directed[r].known, directed[r].word);
      end
      drain_results();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_setting(ph + 1);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         if (ph == 0) hold_request = 1'b1;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (n == RAND_PER_PHASE / 2 && ph == 1) begin
               req_ch.valid <= 1'b0;
               while (spline_q.size() != 0 || tag_q.size() != 0) @(negedge clock);
            end
            send_param(rand_param(), 1'b0, none_w);
         end
         drain_results();
      end

      if (!failed && spline_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
